@@ rtl/core/graph_sketch_bucket_matrix_defines.svh @@
// assertion macros used by the graph sketch checker
`ifndef GRAPH_SKETCH_BUCKET_MATRIX_DEFINES_SVH
`define GRAPH_SKETCH_BUCKET_MATRIX_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define GSBM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gsbm check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define GSBM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gsbm check failed");

`endif

@@ rtl/core/gsbm_pkg.sv @@
// types, constants and helpers of the graph sketch bucket matrix
`timescale 1ns / 1ps

package gsbm_pkg;

  // matrix side, must be a power of two so that the hash reduction is a mask
  localparam int unsigned ROWS       = 16;
  localparam int unsigned HASH_COUNT = 4;

  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned HASH_W = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;
  localparam int unsigned IDX_W  = (ROW_W > HASH_W) ? ROW_W : HASH_W;
  localparam int unsigned CELLS  = ROWS * ROWS;
  localparam int unsigned CELL_W = 2 * ROW_W;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned FP_W       = 6;
  localparam int unsigned PRINT_W    = 32;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned SEED_W     = 32;

  localparam logic [FP_W-1:0] FP_BITS_RESET = FP_W'(16);

  // hash constants; only the low ROW_W bits matter after the reduction
  localparam logic [31:0] ROW_BASE_K = 32'h7c5526b3;
  localparam logic [31:0] ROW_MUL_K  = 32'h9e3779b9;
  localparam logic [31:0] COL_BASE_K = 32'h919cd373;
  localparam logic [31:0] COL_MUL_K  = 32'h85ebca6b;
  localparam logic [31:0] ROW_STEP_K = 32'd17;
  localparam logic [31:0] ROW_SEED_K = 32'd31;
  localparam logic [31:0] COL_STEP_K = 32'd13;
  localparam logic [31:0] COL_SEED_K = 32'd17;

  localparam logic [ROW_W-1:0] ROW_BASE_LO = ROW_BASE_K[ROW_W-1:0];
  localparam logic [ROW_W-1:0] ROW_MUL_LO  = ROW_MUL_K[ROW_W-1:0];
  localparam logic [ROW_W-1:0] COL_BASE_LO = COL_BASE_K[ROW_W-1:0];
  localparam logic [ROW_W-1:0] COL_MUL_LO  = COL_MUL_K[ROW_W-1:0];
  localparam logic [ROW_W-1:0] ROW_STEP_LO = ROW_STEP_K[ROW_W-1:0];
  localparam logic [ROW_W-1:0] ROW_SEED_LO = ROW_SEED_K[ROW_W-1:0];
  localparam logic [ROW_W-1:0] COL_STEP_LO = COL_STEP_K[ROW_W-1:0];
  localparam logic [ROW_W-1:0] COL_SEED_LO = COL_SEED_K[ROW_W-1:0];

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT  = 2'd0,
    KIND_EDGE    = 2'd1,
    KIND_IN_DEG  = 2'd2,
    KIND_OUT_DEG = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FP_BITS = 1'b0,
    CFG_SEED    = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_HASH,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [PRINT_W-1:0] src_print;
    logic [PRINT_W-1:0] dst_print;
    logic [VALUE_W-1:0] weight;
  } cell_t;

  localparam int unsigned CELL_DATA_W = $bits(cell_t);

  typedef struct packed {
    logic               load;
    logic [PRINT_W-1:0] src;
    logic [PRINT_W-1:0] dst;
    logic [HASH_W-1:0]  row_idx;
    logic [HASH_W-1:0]  col_idx;
  } hash_req_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
  } hash_rsp_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] answer;
    logic [COUNT_W-1:0] occupied;
  } result_t;

  function automatic logic [PRINT_W-1:0] print_mask(input logic [FP_W-1:0] bits);
    logic [PRINT_W-1:0] m;
    if (bits >= FP_W'(PRINT_W)) begin
      m = '1;
    end else begin
      m = (PRINT_W'(1) << bits) - PRINT_W'(1);
    end
    return m;
  endfunction

endpackage

@@ rtl/core/graph_sketch_bucket_matrix.sv @@
// top level of the graph sketch bucket matrix
//
//   channel  | handshake                 | words
//   ---------+---------------------------+---------------------------------------
//   input    | in_valid_i / in_stall_o   | kind, src/dst fingerprint, edge value
//   output   | out_valid_o / out_stall_i | hit, answer, occupied cells
//   config   | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// one word at a time: each word runs the prep, hash, scan and final states
// before the next accept, with n cell probes through the single read port of
// the cell memory (1 to HASH_COUNT^2 for insert and edge query, HASH_COUNT*ROWS
// for degree queries). occupied marks sit in flops and clear at reset at once,
// so no clearing pass. a stalled output holds the finished word and the
// sequencer waits in its final state until the output register frees up.
`timescale 1ns / 1ps

module graph_sketch_bucket_matrix (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [gsbm_pkg::KIND_W-1:0]         kind_i,
  input  logic [gsbm_pkg::PRINT_W-1:0]        src_fingerprint_i,
  input  logic [gsbm_pkg::PRINT_W-1:0]        dst_fingerprint_i,
  input  logic [gsbm_pkg::VALUE_W-1:0]        edge_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic [gsbm_pkg::VALUE_W-1:0]        answer_o,
  output logic [gsbm_pkg::COUNT_W-1:0]        occupied_cells_o,
  input  logic                                cfg_we_i,
  input  logic [gsbm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gsbm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  logic [gsbm_pkg::FP_W-1:0]   fp_bits_q;
  logic [gsbm_pkg::SEED_W-1:0] seed_q;

  logic                         busy;
  logic                         start;
  gsbm_pkg::hash_req_t          hash_req;
  gsbm_pkg::hash_rsp_t          hash_rsp;
  logic                         ram_we;
  logic [gsbm_pkg::CELL_W-1:0]  ram_waddr, ram_raddr;
  logic [gsbm_pkg::CELL_DATA_W-1:0] ram_wdata, ram_rdata;
  logic                         res_valid, res_ready;
  gsbm_pkg::result_t            res;

  logic                         out_valid_q, out_valid_d;
  gsbm_pkg::result_t            out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_bits_q <= gsbm_pkg::FP_BITS_RESET;
      seed_q    <= '0;
    end else if (cfg_we_i) begin
      case (gsbm_pkg::cfg_idx_e'(cfg_index_i))
        gsbm_pkg::CFG_FP_BITS: fp_bits_q <= cfg_wdata_i[gsbm_pkg::FP_W-1:0];
        gsbm_pkg::CFG_SEED:    seed_q    <= cfg_wdata_i[gsbm_pkg::SEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;

  gsbm_hash u_hash (
    .clk_i  (clk_i),
    .seed_i (seed_q),
    .req_i  (hash_req),
    .rsp_o  (hash_rsp)
  );

  gsbm_ram #(
    .WIDTH (gsbm_pkg::CELL_DATA_W),
    .DEPTH (gsbm_pkg::CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  gsbm_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .kind_i      (kind_i),
    .src_i       (src_fingerprint_i),
    .dst_i       (dst_fingerprint_i),
    .value_i     (edge_value_i),
    .fp_bits_i   (fp_bits_q),
    .busy_o      (busy),
    .hash_req_o  (hash_req),
    .hash_rsp_i  (hash_rsp),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register, free when empty or being taken
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = out_q.hit;
  assign answer_o         = out_q.answer;
  assign occupied_cells_o = out_q.occupied;

endmodule

@@ rtl/core/gsbm_ram.sv @@
// generic single-write, single-read memory with registered read data
`timescale 1ns / 1ps

module gsbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/gsbm_hash.sv @@
// row and column hashing of the fingerprints
`timescale 1ns / 1ps

module gsbm_hash (
  input  logic                         clk_i,
  input  logic [gsbm_pkg::SEED_W-1:0]  seed_i,
  input  gsbm_pkg::hash_req_t          req_i,
  output gsbm_pkg::hash_rsp_t          rsp_o
);

  logic [gsbm_pkg::ROW_W-1:0] seed_lo;
  logic [gsbm_pkg::ROW_W-1:0] rbase_q, cbase_q, rofs_q, cofs_q;
  logic [gsbm_pkg::ROW_W-1:0] rsum_q, csum_q;
  logic [gsbm_pkg::ROW_W-1:0] rstep, cstep;

  assign seed_lo = seed_i[gsbm_pkg::ROW_W-1:0];

  // seed terms follow the seed register in the next cycle
  always_ff @(posedge clk_i) begin
    rbase_q <= gsbm_pkg::ROW_BASE_LO ^
               gsbm_pkg::ROW_W'(seed_lo * gsbm_pkg::ROW_MUL_LO);
    cbase_q <= gsbm_pkg::COL_BASE_LO ^
               gsbm_pkg::ROW_W'(seed_lo * gsbm_pkg::COL_MUL_LO);
    rofs_q  <= gsbm_pkg::ROW_W'(seed_lo * gsbm_pkg::ROW_SEED_LO);
    cofs_q  <= gsbm_pkg::ROW_W'(seed_lo * gsbm_pkg::COL_SEED_LO);
    if (req_i.load) begin
      rsum_q <= gsbm_pkg::ROW_W'((req_i.src[gsbm_pkg::ROW_W-1:0] ^ rbase_q) + rofs_q);
      csum_q <= gsbm_pkg::ROW_W'((req_i.dst[gsbm_pkg::ROW_W-1:0] ^ cbase_q) + cofs_q);
    end
  end

  assign rstep = gsbm_pkg::ROW_W'(req_i.row_idx * gsbm_pkg::ROW_STEP_LO);
  assign cstep = gsbm_pkg::ROW_W'(req_i.col_idx * gsbm_pkg::COL_STEP_LO);

  assign rsp_o.row = gsbm_pkg::ROW_W'(rsum_q + rstep);
  assign rsp_o.col = gsbm_pkg::ROW_W'(csum_q + cstep);

endmodule

@@ rtl/core/gsbm_scan.sv @@
// sequencer that probes and updates the bucket memory
`timescale 1ns / 1ps

module gsbm_scan (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [gsbm_pkg::KIND_W-1:0]        kind_i,
  input  logic [gsbm_pkg::PRINT_W-1:0]       src_i,
  input  logic [gsbm_pkg::PRINT_W-1:0]       dst_i,
  input  logic [gsbm_pkg::VALUE_W-1:0]       value_i,
  input  logic [gsbm_pkg::FP_W-1:0]          fp_bits_i,
  output logic                               busy_o,
  output gsbm_pkg::hash_req_t                hash_req_o,
  input  gsbm_pkg::hash_rsp_t                hash_rsp_i,
  output logic                               ram_we_o,
  output logic [gsbm_pkg::CELL_W-1:0]        ram_waddr_o,
  output logic [gsbm_pkg::CELL_DATA_W-1:0]   ram_wdata_o,
  output logic [gsbm_pkg::CELL_W-1:0]        ram_raddr_o,
  input  logic [gsbm_pkg::CELL_DATA_W-1:0]   ram_rdata_i,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output gsbm_pkg::result_t                  res_o
);

  gsbm_pkg::state_e state_q, state_d;
  gsbm_pkg::kind_e  kind_q;

  logic [gsbm_pkg::PRINT_W-1:0] src_q, dst_q;
  logic [gsbm_pkg::VALUE_W-1:0] value_q;

  logic [gsbm_pkg::HASH_W-1:0] outer_q, outer_d;
  logic [gsbm_pkg::IDX_W-1:0]  inner_q, inner_d;
  logic                        issue_on_q, issue_on_d;

  logic                        ev_valid_q, ev_valid_d;
  logic                        ev_last_q, ev_last_d;
  logic [gsbm_pkg::CELL_W-1:0] ev_addr_q;
  logic                        ev_used_q;

  logic                         hit_q, hit_d;
  logic [gsbm_pkg::VALUE_W-1:0] acc_q, acc_d;
  logic [gsbm_pkg::COUNT_W-1:0] count_q, count_d;
  logic [gsbm_pkg::CELLS-1:0]   used_q, used_d;

  logic                         probe_mode;
  logic [gsbm_pkg::IDX_W-1:0]   last_inner;
  logic                         issue_last;
  logic [gsbm_pkg::CELL_W-1:0]  issue_addr;
  logic [gsbm_pkg::PRINT_W-1:0] mask, ms, md;
  gsbm_pkg::cell_t              rd;
  logic                         src_match, dst_match;
  logic                         finish;

  // insert and edge query walk the candidate grid, degree queries walk lines
  assign probe_mode = (kind_q == gsbm_pkg::KIND_INSERT) || (kind_q == gsbm_pkg::KIND_EDGE);
  assign last_inner = probe_mode ? gsbm_pkg::IDX_W'(gsbm_pkg::HASH_COUNT - 1)
                                 : gsbm_pkg::IDX_W'(gsbm_pkg::ROWS - 1);
  assign issue_last = issue_on_q &&
                      (outer_q == gsbm_pkg::HASH_W'(gsbm_pkg::HASH_COUNT - 1)) &&
                      (inner_q == last_inner);

  assign hash_req_o.load    = (state_q == gsbm_pkg::ST_HASH);
  assign hash_req_o.src     = src_q;
  assign hash_req_o.dst     = dst_q;
  assign hash_req_o.row_idx = outer_q;
  assign hash_req_o.col_idx = probe_mode ? inner_q[gsbm_pkg::HASH_W-1:0] : outer_q;

  always_comb begin
    case (kind_q)
      gsbm_pkg::KIND_IN_DEG:  issue_addr = {inner_q[gsbm_pkg::ROW_W-1:0], hash_rsp_i.col};
      gsbm_pkg::KIND_OUT_DEG: issue_addr = {hash_rsp_i.row, inner_q[gsbm_pkg::ROW_W-1:0]};
      default:                issue_addr = {hash_rsp_i.row, hash_rsp_i.col};
    endcase
  end

  assign ram_raddr_o = issue_addr;
  assign ram_waddr_o = ev_addr_q;

  assign mask      = gsbm_pkg::print_mask(fp_bits_i);
  assign ms        = src_q & mask;
  assign md        = dst_q & mask;
  assign rd        = gsbm_pkg::cell_t'(ram_rdata_i);
  assign src_match = ((rd.src_print & mask) == ms);
  assign dst_match = ((rd.dst_print & mask) == md);

  always_comb begin
    state_d     = state_q;
    outer_d     = outer_q;
    inner_d     = inner_q;
    issue_on_d  = issue_on_q;
    ev_valid_d  = 1'b0;
    ev_last_d   = issue_last;
    hit_d       = hit_q;
    acc_d       = acc_q;
    count_d     = count_q;
    used_d      = used_q;
    ram_we_o    = 1'b0;
    ram_wdata_o = {ms, md, value_q};
    res_valid_o = 1'b0;
    finish      = 1'b0;

    case (state_q)
      gsbm_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = gsbm_pkg::ST_PREP;
        end
      end
      // a wait state for the seed terms to settle after a seed write
      gsbm_pkg::ST_PREP: begin
        state_d = gsbm_pkg::ST_HASH;
      end
      gsbm_pkg::ST_HASH: begin
        outer_d    = '0;
        inner_d    = '0;
        issue_on_d = 1'b1;
        hit_d      = 1'b0;
        acc_d      = '0;
        state_d    = gsbm_pkg::ST_SCAN;
      end
      gsbm_pkg::ST_SCAN: begin
        if (issue_on_q) begin
          ev_valid_d = 1'b1;
          if (inner_q == last_inner) begin
            inner_d = '0;
            outer_d = gsbm_pkg::HASH_W'(outer_q + 1'b1);
          end else begin
            inner_d = gsbm_pkg::IDX_W'(inner_q + 1'b1);
          end
          if (issue_last) begin
            issue_on_d = 1'b0;
          end
        end
        if (ev_valid_q) begin
          case (kind_q)
            gsbm_pkg::KIND_INSERT: begin
              if (!ev_used_q) begin
                ram_we_o          = 1'b1;
                used_d[ev_addr_q] = 1'b1;
                count_d           = gsbm_pkg::COUNT_W'(count_q + 1'b1);
                hit_d             = 1'b1;
                finish            = 1'b1;
              end else if (src_match && dst_match) begin
                // keep the prints as stored, replace the weight
                ram_we_o    = 1'b1;
                ram_wdata_o = {rd.src_print, rd.dst_print, value_q};
                hit_d       = 1'b1;
                finish      = 1'b1;
              end
            end
            gsbm_pkg::KIND_EDGE: begin
              if (ev_used_q && src_match && dst_match) begin
                acc_d  = rd.weight;
                hit_d  = 1'b1;
                finish = 1'b1;
              end
            end
            gsbm_pkg::KIND_IN_DEG: begin
              if (ev_used_q && dst_match) begin
                acc_d = acc_q + rd.weight;
                hit_d = 1'b1;
              end
            end
            gsbm_pkg::KIND_OUT_DEG: begin
              if (ev_used_q && src_match) begin
                acc_d = acc_q + rd.weight;
                hit_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
          if (ev_last_q) begin
            finish = 1'b1;
          end
        end
        // a probe issued past the finishing one is dropped
        if (finish) begin
          issue_on_d = 1'b0;
          ev_valid_d = 1'b0;
          state_d    = gsbm_pkg::ST_FIN;
        end
      end
      gsbm_pkg::ST_FIN: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = gsbm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gsbm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= gsbm_pkg::ST_IDLE;
      outer_q    <= '0;
      inner_q    <= '0;
      issue_on_q <= 1'b0;
      ev_valid_q <= 1'b0;
      ev_last_q  <= 1'b0;
      hit_q      <= 1'b0;
      acc_q      <= '0;
      count_q    <= '0;
      used_q     <= '0;
    end else begin
      state_q    <= state_d;
      outer_q    <= outer_d;
      inner_q    <= inner_d;
      issue_on_q <= issue_on_d;
      ev_valid_q <= ev_valid_d;
      ev_last_q  <= ev_last_d;
      hit_q      <= hit_d;
      acc_q      <= acc_d;
      count_q    <= count_d;
      used_q     <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == gsbm_pkg::ST_IDLE)) begin
      kind_q  <= gsbm_pkg::kind_e'(kind_i);
      src_q   <= src_i;
      dst_q   <= dst_i;
      value_q <= value_i;
    end
    ev_addr_q <= issue_addr;
    ev_used_q <= used_q[issue_addr];
  end

  assign busy_o       = (state_q != gsbm_pkg::ST_IDLE);
  assign res_o.hit    = hit_q;
  assign res_o.answer = hit_q ? acc_q : '0;
  assign res_o.occupied = count_q;

endmodule

@@ rtl/core/gsbm_checker.sv @@
// port-level checks of the graph sketch bucket matrix and their binding
`timescale 1ns / 1ps
`include "graph_sketch_bucket_matrix_defines.svh"

module gsbm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         hit_o,
  input logic [gsbm_pkg::VALUE_W-1:0] answer_o,
  input logic [gsbm_pkg::COUNT_W-1:0] occupied_cells_o
);

  // a stalled result word stays put
  `GSBM_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(hit_o) && $stable(answer_o) && $stable(occupied_cells_o))

  // a miss and an insert without a hit report a zero answer
  `GSBM_ASSERT_IMP(a_miss_zero, out_valid_o && !hit_o, answer_o == '0)

  // once a word is taken the input side closes for its processing
  `GSBM_ASSERT_NXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o)

  // a new result only comes out of a word in progress
  `GSBM_ASSERT_IMP(a_result_from_work, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind graph_sketch_bucket_matrix gsbm_checker u_gsbm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .hit_o            (hit_o),
  .answer_o         (answer_o),
  .occupied_cells_o (occupied_cells_o)
);

@@ test/tb_graph_sketch_bucket_matrix.sv @@
// self-checking testbench of the graph sketch bucket matrix
`timescale 1ns / 1ps

module tb_graph_sketch_bucket_matrix;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PHASE_OPS    = 100;
  localparam int unsigned PHASES       = 7;
  localparam int unsigned POOL_DEPTH   = 16;

  // fingerprint_bits words per random phase; the fifth carries junk above bit 5
  localparam logic [gsbm_pkg::CFG_DATA_W-1:0] FP_WORDS [PHASES] =
    '{32'd16, 32'd32, 32'd0, 32'd1, 32'hffff_ffe8, 32'd31, 32'd63};
  localparam int unsigned IDLE_PCTS [PHASES] = '{25, 15, 0, 30, 20, 25, 0};

  typedef struct packed {
    gsbm_pkg::kind_e              kind;
    logic [gsbm_pkg::PRINT_W-1:0] src;
    logic [gsbm_pkg::PRINT_W-1:0] dst;
    logic [gsbm_pkg::VALUE_W-1:0] weight;
  } sketch_op_t;

  logic                            clk_i             = 1'b0;
  logic                            rst_ni            = 1'b0;
  logic                            in_valid_i        = 1'b0;
  logic                            in_stall_o;
  logic [gsbm_pkg::KIND_W-1:0]     kind_i            = '0;
  logic [gsbm_pkg::PRINT_W-1:0]    src_fingerprint_i = '0;
  logic [gsbm_pkg::PRINT_W-1:0]    dst_fingerprint_i = '0;
  logic [gsbm_pkg::VALUE_W-1:0]    edge_value_i      = '0;
  logic                            out_valid_o;
  logic                            out_stall_i       = 1'b0;
  logic                            hit_o;
  logic [gsbm_pkg::VALUE_W-1:0]    answer_o;
  logic [gsbm_pkg::COUNT_W-1:0]    occupied_cells_o;
  logic                            cfg_we_i          = 1'b0;
  logic [gsbm_pkg::CFG_IDX_W-1:0]  cfg_index_i       = '0;
  logic [gsbm_pkg::CFG_DATA_W-1:0] cfg_wdata_i       = '0;

  graph_sketch_bucket_matrix dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind_i),
    .src_fingerprint_i (src_fingerprint_i),
    .dst_fingerprint_i (dst_fingerprint_i),
    .edge_value_i      (edge_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .hit_o             (hit_o),
    .answer_o          (answer_o),
    .occupied_cells_o  (occupied_cells_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow copy of the bucket matrix and its settings
  logic                         bucket_used   [gsbm_pkg::CELLS];
  logic [gsbm_pkg::PRINT_W-1:0] bucket_src    [gsbm_pkg::CELLS];
  logic [gsbm_pkg::PRINT_W-1:0] bucket_dst    [gsbm_pkg::CELLS];
  logic [gsbm_pkg::VALUE_W-1:0] bucket_weight [gsbm_pkg::CELLS];
  logic [gsbm_pkg::COUNT_W-1:0] bucket_count;
  logic [gsbm_pkg::FP_W-1:0]    model_fp_bits;
  logic [gsbm_pkg::SEED_W-1:0]  model_seed;

  sketch_op_t                   op_queue[$];
  gsbm_pkg::result_t            awaited_answers[$];
  logic [gsbm_pkg::PRINT_W-1:0] src_pool[$];
  logic [gsbm_pkg::PRINT_W-1:0] dst_pool[$];
  sketch_op_t                   drv_op;
  int unsigned                  idle_pct   = 0;
  int unsigned                  gap_left   = 0;
  int unsigned                  stall_left = 0;
  int unsigned                  miss_count = 0;
  int unsigned                  cycle_count = 0;

  function automatic gsbm_pkg::result_t apply_sketch_op(sketch_op_t op);
    logic [gsbm_pkg::PRINT_W-1:0] mask, ms, md, rbase, cbase, h;
    logic [gsbm_pkg::ROW_W-1:0]   rsel [gsbm_pkg::HASH_COUNT];
    logic [gsbm_pkg::ROW_W-1:0]   csel [gsbm_pkg::HASH_COUNT];
    logic                         placed, found;
    int unsigned                  off;
    gsbm_pkg::result_t            res;
    mask = '1;
    if (model_fp_bits < gsbm_pkg::FP_W'(gsbm_pkg::PRINT_W))
      mask = ~({gsbm_pkg::PRINT_W{1'b1}} << model_fp_bits);
    ms = op.src & mask;
    md = op.dst & mask;
    rbase = gsbm_pkg::ROW_BASE_K ^ (model_seed * gsbm_pkg::ROW_MUL_K);
    cbase = gsbm_pkg::COL_BASE_K ^ (model_seed * gsbm_pkg::COL_MUL_K);
    for (int unsigned i = 0; i < gsbm_pkg::HASH_COUNT; i++) begin
      h = (op.src ^ rbase) + (i * gsbm_pkg::ROW_STEP_K + model_seed * gsbm_pkg::ROW_SEED_K);
      rsel[i] = gsbm_pkg::ROW_W'(h % gsbm_pkg::ROWS);
      h = (op.dst ^ cbase) + (i * gsbm_pkg::COL_STEP_K + model_seed * gsbm_pkg::COL_SEED_K);
      csel[i] = gsbm_pkg::ROW_W'(h % gsbm_pkg::ROWS);
    end
    res = '0;
    placed = 1'b0;
    if (op.kind == gsbm_pkg::KIND_INSERT || op.kind == gsbm_pkg::KIND_EDGE) begin
      // row-major bucket walk; insert stops at empty or match, edge at a match
      for (int unsigned i = 0; i < gsbm_pkg::HASH_COUNT && !placed; i++) begin
        for (int unsigned j = 0; j < gsbm_pkg::HASH_COUNT && !placed; j++) begin
          off = rsel[i] * gsbm_pkg::ROWS + csel[j];
          if (!bucket_used[off]) begin
            if (op.kind == gsbm_pkg::KIND_INSERT) begin
              bucket_used[off]   = 1'b1;
              bucket_src[off]    = ms;
              bucket_dst[off]    = md;
              bucket_weight[off] = op.weight;
              bucket_count++;
              placed = 1'b1;
            end
          end else if ((bucket_src[off] & mask) == ms && (bucket_dst[off] & mask) == md) begin
            if (op.kind == gsbm_pkg::KIND_INSERT) bucket_weight[off] = op.weight;
            else res.answer = bucket_weight[off];
            placed = 1'b1;
          end
        end
      end
      res.hit = placed;
    end else begin
      // repeated hash lines are scanned again and count twice
      for (int unsigned k = 0; k < gsbm_pkg::HASH_COUNT; k++) begin
        for (int unsigned r = 0; r < gsbm_pkg::ROWS; r++) begin
          off = (op.kind == gsbm_pkg::KIND_IN_DEG) ? r * gsbm_pkg::ROWS + csel[k]
                                                   : rsel[k] * gsbm_pkg::ROWS + r;
          found = (op.kind == gsbm_pkg::KIND_IN_DEG) ? ((bucket_dst[off] & mask) == md)
                                                     : ((bucket_src[off] & mask) == ms);
          if (bucket_used[off] && found) begin
            res.answer += bucket_weight[off];
            res.hit = 1'b1;
          end
        end
      end
    end
    res.occupied = bucket_count;
    return res;
  endfunction

  function automatic void push_op(gsbm_pkg::kind_e k, logic [gsbm_pkg::PRINT_W-1:0] s,
                                  logic [gsbm_pkg::PRINT_W-1:0] d,
                                  logic [gsbm_pkg::VALUE_W-1:0] w);
    sketch_op_t op;
    op.kind   = k;
    op.src    = s;
    op.dst    = d;
    op.weight = w;
    op_queue.insert(op_queue.size(), op);
  endfunction

  // about half the time reuse recent prints so that inserts get queried and updated
  function automatic logic [gsbm_pkg::PRINT_W-1:0] draw_print(
      ref logic [gsbm_pkg::PRINT_W-1:0] pool[$]);
    logic [gsbm_pkg::PRINT_W-1:0] v;
    int unsigned                  pick;
    pick = $urandom_range(9);
    v = $urandom();
    if (pick < 5 && pool.size() != 0) v = pool[$urandom_range(pool.size() - 1)];
    else if (pick < 7) v[3:0] = 4'h3;  // crowd one set of candidate lines
    else if (pick == 7) v = ($urandom_range(1) != 0) ? '1 : '0;
    if (pool.size() == POOL_DEPTH) void'(pool.pop_front());
    pool.insert(pool.size(), v);
    return v;
  endfunction

  task automatic queue_random_ops(int unsigned count);
    int unsigned                  roll;
    gsbm_pkg::kind_e              k;
    logic [gsbm_pkg::VALUE_W-1:0] w;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 40) k = gsbm_pkg::KIND_INSERT;
      else if (roll < 70) k = gsbm_pkg::KIND_EDGE;
      else if (roll < 85) k = gsbm_pkg::KIND_IN_DEG;
      else k = gsbm_pkg::KIND_OUT_DEG;
      w = {$urandom(), $urandom()};
      if ($urandom_range(15) == 0) w = ($urandom_range(1) != 0) ? '1 : '0;
      push_op(k, draw_print(src_pool), draw_print(dst_pool), w);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (op_queue.size() != 0 || in_valid_i || awaited_answers.size() != 0);
  endtask

  task automatic set_config(logic [gsbm_pkg::CFG_DATA_W-1:0] fp_word,
                            logic [gsbm_pkg::CFG_DATA_W-1:0] seed_word);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= gsbm_pkg::CFG_FP_BITS;
    cfg_wdata_i <= fp_word;
    @(posedge clk_i);
    cfg_index_i <= gsbm_pkg::CFG_SEED;
    cfg_wdata_i <= seed_word;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_fp_bits = fp_word[gsbm_pkg::FP_W-1:0];
    model_seed    = seed_word;
    @(negedge clk_i);
  endtask

  // input side: present queued words, with random bursts of idle cycles
  always @(posedge clk_i or negedge rst_ni) begin
    logic nv;
    if (!rst_ni) begin
      in_valid_i        <= 1'b0;
      kind_i            <= gsbm_pkg::KIND_INSERT;
      src_fingerprint_i <= '0;
      dst_fingerprint_i <= '0;
      edge_value_i      <= '0;
      gap_left = 0;
    end else begin
      nv = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        awaited_answers.insert(awaited_answers.size(), apply_sketch_op(drv_op));
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0 && idle_pct != 0) begin
          gap_left--;
        end else if (op_queue.size() != 0) begin
          gap_left = 0;
          if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            gap_left = $urandom_range(12);
          end else begin
            drv_op = op_queue.pop_front();
            nv = 1'b1;
            kind_i            <= drv_op.kind;
            src_fingerprint_i <= drv_op.src;
            dst_fingerprint_i <= drv_op.dst;
            edge_value_i      <= drv_op.weight;
          end
        end
      end
      in_valid_i <= nv;
    end
  end

  // output side: check each result word and stall in random bursts
  always @(posedge clk_i or negedge rst_ni) begin
    gsbm_pkg::result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_answers.size() == 0) begin
          miss_count++;
          if (miss_count <= 10)
            $display("unexpected result word at %0t: hit %0b answer %h occupied %0d",
                     $time, hit_o, answer_o, occupied_cells_o);
        end else begin
          want = awaited_answers.pop_front();
          if (hit_o !== want.hit || answer_o !== want.answer ||
              occupied_cells_o !== want.occupied) begin
            miss_count++;
            if (miss_count <= 10)
              $display({"result mismatch at %0t (expected/actual): ",
                        "hit %0b/%0b answer %h/%h occupied %0d/%0d"},
                       $time, want.hit, hit_o, want.answer, answer_o, want.occupied,
                       occupied_cells_o);
          end
        end
      end
      if (stall_left > 0 && idle_pct != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        stall_left = $urandom_range(12);
        out_stall_i <= 1'b1;
      end else begin
        stall_left = 0;
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("graph_sketch_bucket_matrix test failed");
      $finish;
    end
  end

  initial begin
    logic [gsbm_pkg::CFG_DATA_W-1:0] seed_word;
    for (int unsigned n = 0; n < gsbm_pkg::CELLS; n++) begin
      bucket_used[n]   = 1'b0;
      bucket_src[n]    = '0;
      bucket_dst[n]    = '0;
      bucket_weight[n] = '0;
    end
    bucket_count  = '0;
    model_fp_bits = gsbm_pkg::FP_BITS_RESET;
    model_seed    = '0;
    idle_pct      = 20;

    // reset settings: empty matrix, extreme prints, updates, masked-off upper bits
    push_op(gsbm_pkg::KIND_EDGE, '0, '0, '1);
    push_op(gsbm_pkg::KIND_IN_DEG, $urandom(), '0, '0);
    push_op(gsbm_pkg::KIND_OUT_DEG, '0, $urandom(), '0);
    push_op(gsbm_pkg::KIND_INSERT, '0, '0, '0);
    push_op(gsbm_pkg::KIND_INSERT, '1, '1, '1);
    push_op(gsbm_pkg::KIND_EDGE, '0, '0, '0);
    push_op(gsbm_pkg::KIND_EDGE, '1, '1, '0);
    push_op(gsbm_pkg::KIND_INSERT, '0, '0, 64'h8000_0000_0000_0001);
    push_op(gsbm_pkg::KIND_EDGE, '0, '0, '1);
    push_op(gsbm_pkg::KIND_IN_DEG, $urandom(), '1, '0);
    push_op(gsbm_pkg::KIND_OUT_DEG, '1, $urandom(), '0);
    push_op(gsbm_pkg::KIND_INSERT, 32'h0001_0000, 32'hffff_0000, 64'd5);
    for (int unsigned k = 0; k < 8; k++)
      push_op(gsbm_pkg::KIND_INSERT, 32'h0000_0a03 + (k << 4), 32'h0000_0b07,
              {$urandom(), $urandom()});
    push_op(gsbm_pkg::KIND_IN_DEG, $urandom(), 32'h0000_0b07, '0);
    push_op(gsbm_pkg::KIND_OUT_DEG, 32'h0000_0a13, $urandom(), '0);
    push_op(gsbm_pkg::KIND_EDGE, 32'h0000_0a83, 32'h0000_0b07, '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    // no fingerprint bits: every occupied bucket matches
    set_config(32'd0, '1);
    push_op(gsbm_pkg::KIND_INSERT, $urandom(), $urandom(), {$urandom(), $urandom()});
    push_op(gsbm_pkg::KIND_EDGE, $urandom(), $urandom(), '0);
    push_op(gsbm_pkg::KIND_IN_DEG, $urandom(), $urandom(), '0);
    push_op(gsbm_pkg::KIND_OUT_DEG, $urandom(), $urandom(), '0);
    wait_drained();

    for (int unsigned p = 0; p < PHASES; p++) begin
      seed_word = $urandom();
      if (p == 1) seed_word = '0;
      else if (p == 3) seed_word = '1;
      set_config(FP_WORDS[p], seed_word);
      idle_pct = IDLE_PCTS[p];
      queue_random_ops(PHASE_OPS);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (miss_count == 0) begin
      $display("graph_sketch_bucket_matrix test passed");
    end else begin
      $display("graph_sketch_bucket_matrix test failed");
    end
    $finish;
  end

endmodule

@@ graph_sketch_bucket_matrix.f @@
+incdir+rtl/core
rtl/core/gsbm_pkg.sv
rtl/core/gsbm_ram.sv
rtl/core/gsbm_hash.sv
rtl/core/gsbm_scan.sv
rtl/core/graph_sketch_bucket_matrix.sv
rtl/core/gsbm_checker.sv
test/tb_graph_sketch_bucket_matrix.sv
